/* rtl/core/pvrtc_texel_decoder_assert.svh */
// Assertion macros for the PVRTC texel decoder.
// No dependencies; included by the files that carry assertions.
`ifndef PVRTC_TEXEL_DECODER_ASSERT_SVH
`define PVRTC_TEXEL_DECODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PVRTC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PVRTC_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PVRTC_ASSERT(lbl, clk, rst, prop, msg)
`define PVRTC_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

/* rtl/core/pvrtc_pkg.sv */
// Shared types and constants of the PVRTC texel decoder.
// No dependencies; imported by the front, the back, the top level and the testbench.
package pvrtc_pkg;

  localparam int unsigned PIX_W     = 10;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned BADDR_W   = 12;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned LOG_W     = 4;
  localparam int unsigned MADDR_W   = 20;
  localparam int unsigned UV_W      = 9;
  localparam int unsigned SHIFT_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_BIT_MODE = 2'd2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd256;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd256;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH) + 1;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [3:0][7:0]  rgba_t;

  typedef struct packed {
    logic               kind;
    logic [BADDR_W-1:0] block_addr;
    logic [31:0]        modulation_word;
    logic [31:0]        colour_word;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       out_of_range;
  } out_item_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic                         is_load;
    logic                         wr_en;
    logic [BADDR_W-1:0]           waddr;
    logic [63:0]                  wdata;
    logic                         oor;
    logic [3:0]                   hit;
    logic [3:0][MADDR_W-1:0]      addr;
    logic [UV_W-1:0]              u;
    logic [UV_W-1:0]              v;
    logic [1:0]                   hold;
    logic                         two_bit;
    logic [SHIFT_W-1:0]           mod_shift;
  } cmd_t;

  typedef struct packed {
    logic [2:0] inflight;
    logic       load_pop;
  } back_status_t;

endpackage

/* rtl/core/pvrtc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pvrtc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/pvrtc_fifo.sv */
// Small register queue used between the front and the back and at the output.
// No dependencies; DEPTH must be a power of two.
module pvrtc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == ($clog2(DEPTH) + 1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

/* rtl/core/pvrtc_front.sv */
// Front of the decoder: configuration registers, item acceptance and the
// neighbor block address computation. Depends on pvrtc_pkg.
module pvrtc_front #(
  parameter int unsigned MAX_BLOCKS = 4096,
  parameter int unsigned MAX_DIM    = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  pvrtc_pkg::in_item_t                 request,
  input  logic                                cfg_valid,
  input  logic [pvrtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pvrtc_pkg::DIM_W-1:0]         cfg_data,
  output logic                                cfg_ready,
  input  logic                                cmd_full,
  output logic                                cmd_push,
  output pvrtc_pkg::cmd_t                     cmd
);
  import pvrtc_pkg::*;

  typedef logic [DIM_W+1:0]   dimx_t;
  typedef logic [MADDR_W:0]   maddrx_t;

  function automatic logic [LOG_W-1:0] flog2(idx_t n);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int k = 0; k < IDX_W; k++) begin
      if (n[k]) r = LOG_W'(k);
    end
    return r;
  endfunction

  // Interleave the low s bits of both indices, then append the rest of the
  // longer axis linearly.
  function automatic logic [MADDR_W-1:0] morton(idx_t i, idx_t j, logic [LOG_W-1:0] s,
                                                 logic i_long);
    logic [MADDR_W-1:0] low;
    logic [MADDR_W-1:0] high;
    idx_t               rest;
    low = '0;
    for (int k = 0; k < IDX_W; k++) begin
      if (k < int'(s)) begin
        low[2*k]   = j[k];
        low[2*k+1] = i[k];
      end
    end
    rest = i_long ? (i >> s) : (j >> s);
    high = MADDR_W'(rest) << {s, 1'b0};
    return low | high;
  endfunction

  dim_t image_width;
  dim_t image_height;
  logic two_bit_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
      two_bit_mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        CFG_TWO_BIT_MODE: two_bit_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign cmd_push  = push && !cmd_full;

  dim_t              w_sat, h_sat, dx, dy;
  logic [DIM_W:0]    x_round, y_round;
  idx_t              bx, by, qx, qy, i0, i1, j0, j1, n_min;
  logic [IDX_W:0]    i0n, j0n;
  logic [LOG_W-1:0]  steps;
  logic              i_long;
  idx_t [3:0]        ci, cj;

  always_comb begin
    w_sat = (dimx_t'(image_width) > dimx_t'(MAX_DIM)) ? dim_t'(MAX_DIM) : image_width;
    h_sat = (dimx_t'(image_height) > dimx_t'(MAX_DIM)) ? dim_t'(MAX_DIM) : image_height;

    x_round = {1'b0, w_sat} + (two_bit_mode ? (DIM_W+1)'(7) : (DIM_W+1)'(3));
    y_round = {1'b0, h_sat} + (DIM_W+1)'(3);
    bx = two_bit_mode ? IDX_W'(x_round >> 3) : IDX_W'(x_round >> 2);
    by = IDX_W'(y_round >> 2);

    // Block grid is offset by half a block.
    dx = dim_t'(request.pixel_x) + (two_bit_mode ? dim_t'(4) : dim_t'(2));
    dy = dim_t'(request.pixel_y) + dim_t'(2);
    qx = two_bit_mode ? IDX_W'(dx >> 3) : IDX_W'(dx >> 2);
    qy = IDX_W'(dy >> 2);

    i0  = (qx == '0) ? bx - 1'b1 : qx - 1'b1;
    j0  = (qy == '0) ? by - 1'b1 : qy - 1'b1;
    i0n = {1'b0, i0} + 1'b1;
    j0n = {1'b0, j0} + 1'b1;
    i1  = (i0n >= {1'b0, bx}) ? '0 : i0n[IDX_W-1:0];
    j1  = (j0n >= {1'b0, by}) ? '0 : j0n[IDX_W-1:0];

    n_min  = (bx < by) ? bx : by;
    steps  = flog2(n_min);
    i_long = (bx > by);

    ci = {i1, i0, i1, i0};
    cj = {j1, j1, j0, j0};

    cmd         = '0;
    cmd.is_load = (request.kind == KIND_LOAD);
    cmd.wr_en   = maddrx_t'(request.block_addr) < maddrx_t'(MAX_BLOCKS);
    cmd.waddr   = request.block_addr;
    cmd.wdata   = {request.colour_word, request.modulation_word};
    cmd.oor     = (dim_t'(request.pixel_x) >= w_sat) || (dim_t'(request.pixel_y) >= h_sat);
    for (int c = 0; c < 4; c++) begin
      cmd.addr[c] = morton(ci[c], cj[c], steps, i_long);
      cmd.hit[c]  = maddrx_t'(cmd.addr[c]) < maddrx_t'(MAX_BLOCKS);
    end
    cmd.u = two_bit_mode ? {1'b0, dx[2:0], 5'd0} : {1'b0, dx[1:0], 6'd0};
    cmd.v = {1'b0, dy[1:0], 6'd0};
    // The block holding the pixel is the right or lower neighbor when the
    // pixel sits in the first half of its block.
    cmd.hold[0]   = two_bit_mode ? ~request.pixel_x[2] : ~request.pixel_x[1];
    cmd.hold[1]   = ~request.pixel_y[1];
    cmd.two_bit   = two_bit_mode;
    cmd.mod_shift = two_bit_mode ? {request.pixel_y[1:0], request.pixel_x[2:0]}
                                 : {request.pixel_y[1:0], request.pixel_x[1:0], 1'b0};
  end

endmodule

/* rtl/core/pvrtc_back.sv */
// Back of the decoder: block store, endpoint expansion, bilinear blend,
// modulation and rounding. Depends on pvrtc_pkg and pvrtc_ram.
module pvrtc_back #(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pvrtc_pkg::cmd_t                   cmd,
  input  logic                              cmd_empty,
  output logic                              cmd_pop,
  input  logic [pvrtc_pkg::OUT_CNT_W-1:0]   out_count,
  output logic                              out_push,
  output pvrtc_pkg::out_item_t              out_data,
  output pvrtc_pkg::back_status_t           status
);
  import pvrtc_pkg::*;

  localparam int unsigned AW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned WT_W   = 17;
  localparam int unsigned PROD_W = 25;
  localparam int unsigned SUM_W  = 24;
  localparam int unsigned MIX_W  = 33;
  localparam logic [1:0]  SEL_PUNCH = 2'd2;
  localparam logic [UV_W-1:0] W_FULL = 9'd256;
  localparam logic [UV_W-1:0] W_N1   = 9'd96;
  localparam logic [UV_W-1:0] W_N2   = 9'd160;
  localparam logic [UV_W-1:0] W_HALF = 9'd128;

  function automatic rgba_t expand(logic [15:0] h, logic is_a);
    rgba_t c;
    if (h[15]) begin
      c[0] = {h[14:10], h[14:12]};
      c[1] = {h[9:5], h[9:7]};
      c[2] = {h[4:0], h[4:2]};
      c[3] = 8'hFF;
    end else begin
      c[0] = {h[11:8], h[11:8]};
      c[1] = {h[7:4], h[7:4]};
      c[2] = is_a ? {h[3:1], h[3:1], h[3:2]} : {h[3:0], h[3:0]};
      c[3] = {h[14:12], h[14:12], h[14:13]};
    end
    return c;
  endfunction

  typedef struct packed {
    logic               oor;
    logic [3:0]         hit;
    logic [UV_W-1:0]    u;
    logic [UV_W-1:0]    v;
    logic [1:0]         hold;
    logic               two_bit;
    logic [SHIFT_W-1:0] mod_shift;
  } s1_meta_t;

  logic credit_ok, rd, wr;
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic [3:0][63:0] rdata;
  s1_meta_t s1;

  assign credit_ok = (5'(out_count) + 5'(status.inflight)) < 5'(OUT_DEPTH);
  assign cmd_pop   = !cmd_empty && (cmd.is_load || credit_ok);
  assign rd        = cmd_pop && !cmd.is_load;
  assign wr        = cmd_pop && cmd.is_load && cmd.wr_en;

  assign status.inflight = 3'(s1_valid) + 3'(s2_valid) + 3'(s3_valid) + 3'(s4_valid)
                         + 3'(s5_valid);
  assign status.load_pop = cmd_pop && cmd.is_load;

  // Four copies of the store, written together, one read port per neighbor.
  for (genvar g = 0; g < 4; g++) begin : g_store
    pvrtc_ram #(.WIDTH(64), .DEPTH(MAX_BLOCKS)) u_ram (
      .clk   (clk),
      .we    (wr),
      .waddr (AW'(cmd.waddr)),
      .wdata (cmd.wdata),
      .re    (rd),
      .raddr (AW'(cmd.addr[g])),
      .rdata (rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      s1_valid <= rd;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      s1.oor       <= cmd.oor;
      s1.hit       <= cmd.hit;
      s1.u         <= cmd.u;
      s1.v         <= cmd.v;
      s1.hold      <= cmd.hold;
      s1.two_bit   <= cmd.two_bit;
      s1.mod_shift <= cmd.mod_shift;
    end
  end

  // Stage 1: expand endpoints, corner weights and modulation weight.
  logic [3:0][63:0]      blk;
  rgba_t [3:0]           ea, eb;
  logic [3:0][WT_W-1:0]  wt;
  logic [UV_W-1:0]       nu, nv, mod_w;
  logic [63:0]           hb;
  logic [31:0]           msh;
  logic [1:0]            sel;
  logic                  punch;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      blk[c] = s1.hit[c] ? rdata[c] : '0;
      ea[c]  = expand(blk[c][63:48], 1'b1);
      eb[c]  = expand(blk[c][47:32], 1'b0);
    end
    nu    = W_FULL - s1.u;
    nv    = W_FULL - s1.v;
    wt[0] = WT_W'({9'd0, nu} * {9'd0, nv});
    wt[1] = WT_W'({9'd0, s1.u} * {9'd0, nv});
    wt[2] = WT_W'({9'd0, nu} * {9'd0, s1.v});
    wt[3] = WT_W'({9'd0, s1.u} * {9'd0, s1.v});
    hb    = blk[s1.hold];
    msh   = hb[31:0] >> s1.mod_shift;
    sel   = msh[1:0];
    punch = 1'b0;
    if (s1.two_bit) begin
      mod_w = sel[0] ? W_FULL : '0;
    end else if (hb[32]) begin
      case (sel)
        2'd0:    mod_w = '0;
        2'd3:    mod_w = W_FULL;
        default: mod_w = W_HALF;
      endcase
      punch = (sel == SEL_PUNCH);
    end else begin
      case (sel)
        2'd0:    mod_w = '0;
        2'd1:    mod_w = W_N1;
        2'd2:    mod_w = W_N2;
        default: mod_w = W_FULL;
      endcase
    end
  end

  rgba_t [3:0]          s2_ca, s2_cb;
  logic [3:0][WT_W-1:0] s2_wt;
  logic [UV_W-1:0]      s2_w, s3_w, s4_w;
  logic                 s2_punch, s3_punch, s4_punch, s5_punch;
  logic                 s2_oor, s3_oor, s4_oor, s5_oor;

  always_ff @(posedge clk) begin
    s2_ca    <= ea;
    s2_cb    <= eb;
    s2_wt    <= wt;
    s2_w     <= mod_w;
    s2_punch <= punch;
    s2_oor   <= s1.oor;
  end

  // Stage 2: per-corner products.
  logic [3:0][3:0][PROD_W-1:0] s3_pa, s3_pb;

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 4; ch++) begin
      for (int c = 0; c < 4; c++) begin
        s3_pa[ch][c] <= {17'd0, s2_ca[c][ch]} * {8'd0, s2_wt[c]};
        s3_pb[ch][c] <= {17'd0, s2_cb[c][ch]} * {8'd0, s2_wt[c]};
      end
    end
    s3_w     <= s2_w;
    s3_punch <= s2_punch;
    s3_oor   <= s2_oor;
  end

  // Stage 3: bilinear sums of both endpoints.
  logic [3:0][SUM_W-1:0] s4_sa, s4_sb;

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 4; ch++) begin
      s4_sa[ch] <= SUM_W'(s3_pa[ch][0] + s3_pa[ch][1] + s3_pa[ch][2] + s3_pa[ch][3]);
      s4_sb[ch] <= SUM_W'(s3_pb[ch][0] + s3_pb[ch][1] + s3_pb[ch][2] + s3_pb[ch][3]);
    end
    s4_w     <= s3_w;
    s4_punch <= s3_punch;
    s4_oor   <= s3_oor;
  end

  // Stage 4: modulation products.
  logic [3:0][MIX_W-1:0] s5_ma, s5_mb;

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 4; ch++) begin
      s5_ma[ch] <= {9'd0, s4_sa[ch]} * {24'd0, s4_w};
      s5_mb[ch] <= {9'd0, s4_sb[ch]} * {24'd0, W_FULL - s4_w};
    end
    s5_punch <= s4_punch;
    s5_oor   <= s4_oor;
  end

  // Stage 5: round, saturate and hand to the output queue.
  logic [MIX_W:0]   mix;
  logic [3:0][7:0]  chan;

  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      mix      = {1'b0, s5_ma[ch]} + {1'b0, s5_mb[ch]} + (MIX_W+1)'(1 << 23);
      chan[ch] = (mix[MIX_W:24] > 10'd255) ? 8'hFF : mix[31:24];
    end
    out_data = '0;
    if (s5_oor) begin
      out_data.out_of_range = 1'b1;
    end else begin
      out_data.red   = chan[0];
      out_data.green = chan[1];
      out_data.blue  = chan[2];
      out_data.alpha = s5_punch ? 8'd0 : chan[3];
    end
  end

  assign out_push = s5_valid;

endmodule

/* rtl/core/pvrtc_texel_decoder.sv */
// Top level of the PVRTC texel decoder: front, command queue, back, result queue.
// Depends on pvrtc_pkg, pvrtc_fifo, pvrtc_front, pvrtc_back and the assertion header.
//
// The decoder holds a store of compressed PVRTC blocks and answers each pixel
// request with one RGBA texel. A load item (kind 0) writes one block and gives
// no result; a pixel item (kind 1) gives exactly one result, in order. Both
// kinds go through the same command queue, so a load never overtakes an
// earlier request. Items are accepted at one per cycle while the command
// queue is not full, and results come out at one per cycle as long as the
// result side keeps popping. The rate is set by the four block reads each
// request needs: the store is kept as four identical RAM copies, written
// together by a load and each read at one neighbor's address, so all four
// neighbors come back in the same cycle. The back pipeline only takes a
// request when the eight-entry result queue has a free slot for it, so it
// never stalls once started. Blocks are undefined until loaded; there is no
// clearing pass. Configuration (width, height, 2bpp mode) must be written
// while the decoder is idle.
`include "pvrtc_texel_decoder_assert.svh"
module pvrtc_texel_decoder #(
  parameter int unsigned MAX_BLOCKS = 4096,
  parameter int unsigned MAX_DIM    = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  pvrtc_pkg::in_item_t              request,
  output logic                             empty,
  input  logic                             pop,
  output pvrtc_pkg::out_item_t             result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pvrtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pvrtc_pkg::DIM_W-1:0]      cfg_data
);
  import pvrtc_pkg::*;

  cmd_t                   cmd_in, cmd_head;
  logic                   cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic [$clog2(CMD_DEPTH):0] cmd_count;
  logic                   out_push, out_full;
  logic [OUT_CNT_W-1:0]   out_count;
  out_item_t              out_data;
  back_status_t           status;

  // The input side reports full whenever the command queue is full.
  assign full = cmd_full;

  pvrtc_front #(.MAX_BLOCKS(MAX_BLOCKS), .MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .request   (request),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  // Command queue decouples acceptance from the store and arithmetic.
  pvrtc_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .full  (cmd_full),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  pvrtc_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_data  (out_data),
    .status    (status)
  );

  // Result queue: the oldest result sits on the result port while not empty.
  pvrtc_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_data),
    .pop   (pop),
    .dout  (result),
    .full  (out_full),
    .empty (empty),
    .count (out_count)
  );

  // The command queue count must agree with its empty flag.
  `PVRTC_NEVER(a_cmd_pop_empty, clk, rst, cmd_pop && (cmd_count == '0), "pop of empty command queue")
  // Credit scheme: a finished result always finds room in the result queue.
  `PVRTC_NEVER(a_out_overflow, clk, rst, out_push && out_full, "result queue overflow")
  // Queued plus in-flight results never exceed the result queue depth.
  `PVRTC_ASSERT(a_credit, clk, rst, (5'(out_count) + 5'(status.inflight)) <= 5'(OUT_DEPTH), "credit exceeded")

endmodule

/* sim/tb.sv */
// Self-checking testbench for the PVRTC texel decoder (pvrtc_texel_decoder).
// Depends on pvrtc_pkg and the decoder RTL; block loads, pixel requests and register
// writes are driven; texels are checked against an in-bench predictor or typed rows.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pvrtc_pkg::*;

  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned FILL_DEPTH  = 1024;
  localparam int unsigned SMALL_DIM   = 128;
  localparam int unsigned DIM_LIMIT   = 1024;
  localparam int unsigned DRAIN_WAIT  = 12;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_ITEMS = 1000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  request = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [DIM_W-1:0]     cfg_data = '0;

  pvrtc_texel_decoder u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: a copy of the block store and of the three registers.
  logic [63:0] block_copy [STORE_DEPTH];
  int unsigned width_reg = 256;
  int unsigned height_reg = 256;
  bit          two_bit_reg = 1'b0;

  out_item_t texel_queue[$];
  int unsigned errors = 0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned texels_checked = 0;
  int unsigned oor_checked = 0;
  int unsigned cycles = 0;
  int unsigned stall_mode = 0;

  // One row of the directed table. Rows with a typed texel skip the predictor.
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t texel;
  } stim_row_t;

  stim_row_t directed[$];

  function automatic int unsigned rep5(int unsigned v);
    return (v << 3) | (v >> 2);
  endfunction

  function automatic int unsigned rep4(int unsigned v);
    return (v << 4) | v;
  endfunction

  function automatic int unsigned rep3(int unsigned v);
    return (v << 5) | (v << 2) | (v >> 1);
  endfunction

  // Widens one 16-bit endpoint to 8 bits per channel (r, g, b, a).
  function automatic void expand_endpoint(input int unsigned half, input bit is_a,
                                          output int unsigned chan [4]);
    if (half[15]) begin
      chan[0] = rep5((half >> 10) & 5'h1F);
      chan[1] = rep5((half >> 5) & 5'h1F);
      chan[2] = rep5(half & 5'h1F);
      chan[3] = 255;
    end else begin
      chan[0] = rep4((half >> 8) & 4'hF);
      chan[1] = rep4((half >> 4) & 4'hF);
      chan[2] = is_a ? rep3((half >> 1) & 3'h7) : rep4(half & 4'hF);
      chan[3] = rep3((half >> 12) & 3'h7);
    end
  endfunction

  // Interleaves block column i and row j; the longer axis fills the top bits.
  function automatic int unsigned morton_addr(int unsigned i, int unsigned j,
                                              int unsigned bx, int unsigned by);
    int unsigned n;
    int unsigned idx;
    int unsigned sh;
    n = bx < by ? bx : by;
    idx = 0;
    sh = 0;
    for (int unsigned k = n; k > 1; k >>= 1) begin
      idx |= ((j & 1) << sh) | ((i & 1) << (sh + 1));
      i >>= 1;
      j >>= 1;
      sh += 2;
    end
    idx |= (bx > by ? i : j) << sh;
    return idx;
  endfunction

  function automatic logic [63:0] read_block(int unsigned i, int unsigned j,
                                             int unsigned bx, int unsigned by);
    int unsigned a;
    a = morton_addr(i, j, bx, by);
    return a < STORE_DEPTH ? block_copy[a] : 64'd0;
  endfunction

  function automatic out_item_t predict_texel(in_item_t it);
    out_item_t t;
    int unsigned w, h, px, py, bw, bx, by, dx, dy, u, v, i0, j0, i1, j1, lx, ly;
    int unsigned mw, sel, wmod;
    int unsigned ci [4];
    int unsigned cj [4];
    int unsigned wt [4];
    int unsigned ca [4];
    int unsigned cb [4];
    longint unsigned sa [4];
    longint unsigned sb [4];
    longint unsigned mix;
    logic [63:0] blk;
    bit punch;
    t = '0;
    punch = 1'b0;
    w = width_reg > DIM_LIMIT ? DIM_LIMIT : width_reg;
    h = height_reg > DIM_LIMIT ? DIM_LIMIT : height_reg;
    px = it.pixel_x;
    py = it.pixel_y;
    if (px >= w || py >= h) begin
      t.out_of_range = 1'b1;
      return t;
    end
    bw = two_bit_reg ? 8 : 4;
    bx = (w + bw - 1) / bw;
    by = (h + 3) / 4;
    // The block grid sits half a block off the pixel grid; edges wrap around.
    dx = px + bw / 2;
    dy = py + 2;
    u = (dx % bw) * 256 / bw;
    v = (dy % 4) * 64;
    i0 = dx / bw == 0 ? bx - 1 : dx / bw - 1;
    j0 = dy / 4 == 0 ? by - 1 : dy / 4 - 1;
    i1 = i0 + 1 >= bx ? 0 : i0 + 1;
    j1 = j0 + 1 >= by ? 0 : j0 + 1;
    ci = '{i0, i1, i0, i1};
    cj = '{j0, j0, j1, j1};
    wt[0] = (256 - u) * (256 - v);
    wt[1] = u * (256 - v);
    wt[2] = (256 - u) * v;
    wt[3] = u * v;
    sa = '{0, 0, 0, 0};
    sb = '{0, 0, 0, 0};
    for (int c = 0; c < 4; c++) begin
      blk = read_block(ci[c], cj[c], bx, by);
      expand_endpoint(blk[63:48], 1'b1, ca);
      expand_endpoint(blk[47:32], 1'b0, cb);
      for (int ch = 0; ch < 4; ch++) begin
        sa[ch] += longint'(ca[ch]) * wt[c];
        sb[ch] += longint'(cb[ch]) * wt[c];
      end
    end
    blk = read_block(px / bw, py / 4, bx, by);
    mw = blk[31:0];
    lx = px % bw;
    ly = py % 4;
    if (two_bit_reg) begin
      wmod = ((mw >> (ly * 8 + lx)) & 1) ? 256 : 0;
    end else begin
      sel = (mw >> ((ly * 4 + lx) * 2)) & 3;
      if (blk[32]) begin
        // Punch-through weights; selector 2 also clears alpha.
        wmod = sel == 0 ? 0 : (sel == 3 ? 256 : 128);
        punch = (sel == 2);
      end else begin
        wmod = sel == 0 ? 0 : (sel == 1 ? 96 : (sel == 2 ? 160 : 256));
      end
    end
    for (int ch = 0; ch < 4; ch++) begin
      mix = (sb[ch] * (256 - wmod) + sa[ch] * wmod + (64'd1 << 23)) >> 24;
      if (mix > 255) mix = 255;
      case (ch)
        0: t.red = mix[7:0];
        1: t.green = mix[7:0];
        2: t.blue = mix[7:0];
        default: t.alpha = mix[7:0];
      endcase
    end
    if (punch) t.alpha = 8'd0;
    return t;
  endfunction

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d texels still expected", cycles,
               texel_queue.size());
      $display("FAIL");
      $finish;
    end
  end

  // Result side: the stall pattern changes now and then, from none to heavy.
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= $urandom_range(0, 3) != 0;
      2: pop <= $urandom_range(0, 1);
      default: pop <= $urandom_range(0, 7) == 0;
    endcase
  end

  // Each accepted texel is compared with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (texel_queue.size() == 0) begin
        errors++;
        $display("Unexpected texel r=%0d g=%0d b=%0d a=%0d oor=%0b", result.red,
                 result.green, result.blue, result.alpha, result.out_of_range);
      end else begin
        want = texel_queue.pop_front();
        texels_checked++;
        if (want.out_of_range) oor_checked++;
        if (result.red !== want.red || result.green !== want.green ||
            result.blue !== want.blue || result.alpha !== want.alpha ||
            result.out_of_range !== want.out_of_range) begin
          errors++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("Texel mismatch: expected r=%0d g=%0d b=%0d a=%0d oor=%0b",
                     want.red, want.green, want.blue, want.alpha, want.out_of_range);
            $display("                got      r=%0d g=%0d b=%0d a=%0d oor=%0b",
                     result.red, result.green, result.blue, result.alpha,
                     result.out_of_range);
          end
        end
      end
    end
  end

  // Drives one item and holds it until accepted. Returns at the next falling edge,
  // with push still high so the caller can either go on or open a gap.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t texel);
    request <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    items_sent++;
    if (it.kind == KIND_LOAD) begin
      block_copy[it.block_addr] = {it.colour_word, it.modulation_word};
    end else begin
      texel_queue.push_back(typed ? texel : predict_texel(it));
    end
    @(negedge clk);
  endtask

  // Sender bursts: a burst of random length, then a random gap.
  int unsigned burst_left = 0;
  task automatic sender_pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 12);
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Waits for every texel, then long enough for a trailing load to land.
  task automatic drain();
    push <= 1'b0;
    while (texel_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_index <= idx;
    cfg_data <= value[DIM_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IMAGE_WIDTH: width_reg = value & 11'h7FF;
      CFG_IMAGE_HEIGHT: height_reg = value & 11'h7FF;
      default: two_bit_reg = value[0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_load(int unsigned addr, logic [31:0] mod_w,
                                         logic [31:0] col_w);
    in_item_t it;
    it = '0;
    it.kind = KIND_LOAD;
    it.block_addr = addr[BADDR_W-1:0];
    it.modulation_word = mod_w;
    it.colour_word = col_w;
    // Pixel bits ride along unused on loads so they toggle too.
    it.pixel_x = $urandom;
    it.pixel_y = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_pixel(int unsigned x, int unsigned y);
    in_item_t it;
    it = '0;
    it.kind = KIND_PIXEL;
    it.block_addr = $urandom;
    it.modulation_word = $urandom;
    it.colour_word = $urandom;
    it.pixel_x = x[PIX_W-1:0];
    it.pixel_y = y[PIX_W-1:0];
    return it;
  endfunction

  // Pixel request for the current settings. Small images only reach blocks
  // below FILL_DEPTH. When both sides are large, requests stay in a 16 by 16
  // block window away from the wrapping edges, whose blocks all sit below
  // address 256; strays there go outside the image when there is room.
  function automatic in_item_t pick_pixel(bit stray);
    int unsigned w, h, bw;
    bit windowed;
    w = width_reg > DIM_LIMIT ? DIM_LIMIT : width_reg;
    h = height_reg > DIM_LIMIT ? DIM_LIMIT : height_reg;
    bw = two_bit_reg ? 8 : 4;
    windowed = (w > SMALL_DIM) && (h > SMALL_DIM);
    if (!windowed) begin
      if (stray || w == 0 || h == 0)
        return make_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
      return make_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1));
    end
    if (stray && w < DIM_LIMIT)
      return make_pixel($urandom_range(w, DIM_LIMIT - 1), $urandom_range(0, 1023));
    if (stray && h < DIM_LIMIT)
      return make_pixel($urandom_range(0, 1023), $urandom_range(h, DIM_LIMIT - 1));
    return make_pixel($urandom_range(bw / 2, bw / 2 + 15 * bw - 1), $urandom_range(2, 61));
  endfunction

  function automatic void add_row(in_item_t it, bit typed = 1'b0);
    stim_row_t r;
    r.item = it;
    r.typed = typed;
    // The only typed texel is the all-zero out-of-range answer.
    r.texel = '0;
    r.texel.out_of_range = 1'b1;
    directed.push_back(r);
  endfunction

  // Random colour words lean toward the special cases: opaque and translucent
  // endpoints and saturating all-ones.
  function automatic logic [31:0] random_colour();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 5))
      0: c = 32'hFFFF_FFFF;
      1: c[31] = 1'b0;
      2: c[15] = 1'b0;
      default: ;
    endcase
    return c;
  endfunction

  // Random phase: mostly loads and in-image pixel requests, some strays.
  task automatic run_phase(input int unsigned n_items);
    in_item_t it;
    out_item_t none;
    none = '0;
    for (int unsigned n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        it = make_load($urandom_range(0, 2) != 0 ? $urandom_range(0, 255)
                                                 : $urandom_range(0, STORE_DEPTH - 1),
                       $urandom, random_colour());
      end else begin
        it = pick_pixel($urandom_range(0, 9) == 0);
      end
      send_item(it, 1'b0, none);
      sender_pace();
      // Once per phase the sender holds off until the decoder has caught up.
      if (n == n_items / 2) begin
        push <= 1'b0;
        while (texel_queue.size() != 0) @(negedge clk);
      end
    end
    drain();
  endtask

  typedef struct {
    int unsigned w;
    int unsigned h;
    bit          two_bit;
  } setting_t;

  initial begin
    setting_t plan [$];
    out_item_t none;
    none = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill the low part of the store first; requests only read blocks there,
    // apart from the edge blocks that the directed loads below write.
    for (int unsigned a = 0; a < FILL_DEPTH; a++) begin
      send_item(make_load(a, $urandom, random_colour()), 1'b0, none);
    end

    // Directed part at reset settings (256 x 256, 4bpp).
    add_row(make_load(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_row(make_load(4095, 32'h0000_0000, 32'h0000_0000));
    add_row(make_load(1, 32'hAAAA_AAAA, 32'h7FFF_0001));
    add_row(make_load(2, 32'h5555_5555, 32'h0000_8000));
    add_row(make_load(3, 32'hE4E4_E4E4, 32'h8000_7FFE));
    // Corner pixels wrap to the last block column and row: blocks (0,63),
    // (1,63) and (63,0) of the 64 by 64 grid.
    add_row(make_load(1365, $urandom, random_colour()));
    add_row(make_load(1367, $urandom, random_colour()));
    add_row(make_load(2730, $urandom, random_colour()));
    add_row(make_pixel(0, 0));
    add_row(make_pixel(255, 255));
    add_row(make_pixel(255, 0));
    add_row(make_pixel(0, 255));
    add_row(make_pixel(4, 0));
    add_row(make_pixel(5, 1));
    add_row(make_pixel(2, 6));
    add_row(make_pixel(7, 7));
    add_row(make_pixel(256, 0), 1'b1);
    add_row(make_pixel(0, 256), 1'b1);
    add_row(make_pixel(1023, 1023), 1'b1);
    add_row(make_pixel(1023, 0), 1'b1);
    add_row(make_pixel(512, 512), 1'b1);
    foreach (directed[k]) send_item(directed[k].item, directed[k].typed, directed[k].texel);
    drain();

    // Settings: tiny, oversized, zero, non power of two counts, both modes.
    plan.push_back('{4, 4, 1'b0});
    plan.push_back('{1, 1, 1'b1});
    plan.push_back('{1024, 1024, 1'b0});
    plan.push_back('{2047, 2047, 1'b1});
    plan.push_back('{0, 16, 1'b0});
    plan.push_back('{16, 0, 1'b1});
    plan.push_back('{24, 40, 1'b0});
    plan.push_back('{100, 3, 1'b1});
    plan.push_back('{64, 8, 1'b1});
    plan.push_back('{8, 64, 1'b0});
    plan.push_back('{32, 32, 1'b1});
    plan.push_back('{$urandom_range(1, 128), $urandom_range(1, 128), $urandom_range(0, 1)});

    run_phase(RANDOM_ITEMS / 13);
    foreach (plan[p]) begin
      write_reg(CFG_IMAGE_WIDTH, plan[p].w);
      write_reg(CFG_IMAGE_HEIGHT, plan[p].h);
      write_reg(CFG_TWO_BIT_MODE, plan[p].two_bit);
      run_phase(RANDOM_ITEMS / 13);
    end

    if (texel_queue.size() != 0) begin
      errors++;
      $display("%0d texels never arrived", texel_queue.size());
    end
    $display("Sent %0d items over %0d register settings; checked %0d texels (%0d out of range).",
             items_sent, plan.size() + 1, texels_checked, oor_checked);
    $display("Mismatches: %0d, total errors: %0d, cycles: %0d", mismatches, errors, cycles);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
